@@ hw/rtl/mtapverb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtapverb_pkg
// Types, constants and fixed-point helpers of the multitap allpass reverb.
// ----------------------------------------------------------------------------
package mtapverb_pkg;

	typedef logic signed [23:0] sample_t;
	typedef logic signed [47:0] wide_t;

	localparam int TAP_COUNT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 18;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SEND     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIX      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd6;

	localparam logic signed [16:0] AP_COEF   = 17'sd22938;
	// ceil(2^44 / 7300): exact floor divide for any room * rate * ratio product
	localparam logic [31:0]        TAP_RECIP = 32'd2409888500;
	localparam int                 TAP_SHIFT = 44;
	localparam logic signed [47:0] DAMP_MID  = 48'sd16384;
	localparam logic signed [47:0] DAMP_SCL  = 48'sd9830;
	localparam logic signed [47:0] DAMP_OFS  = 48'sd3277;
	localparam logic signed [47:0] DAMP_GAIN = 48'sd27853;
	localparam logic signed [47:0] UNITY     = 48'sd32768;

	function automatic logic [6:0] tap_ratio(input logic [2:0] idx);
		logic [6:0] r;
		unique case (idx)
			3'd0: r = 7'd1;
			3'd1: r = 7'd7;
			3'd2: r = 7'd13;
			3'd3: r = 7'd19;
			3'd4: r = 7'd31;
			3'd5: r = 7'd43;
			3'd6: r = 7'd61;
			default: r = 7'd73;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] tap_gain(input logic [2:0] idx);
		logic [15:0] g;
		unique case (idx)
			3'd0: g = 16'd32768;
			3'd1: g = 16'd25206;
			3'd2: g = 16'd20480;
			3'd3: g = 16'd17246;
			3'd4: g = 16'd14895;
			3'd5: g = 16'd13107;
			3'd6: g = 16'd11703;
			default: g = 16'd10570;
		endcase
		return g;
	endfunction

	function automatic logic [15:0] preset_fb(input logic [1:0] mode);
		logic [15:0] f;
		unique case (mode)
			2'd0: f = 16'd27853;
			2'd1: f = 16'd21299;
			2'd2: f = 16'd24576;
			default: f = 16'd18022;
		endcase
		return f;
	endfunction

	function automatic logic [15:0] preset_damp(input logic [1:0] mode);
		logic [15:0] d;
		unique case (mode)
			2'd0: d = 16'd16384;
			2'd1: d = 16'd19661;
			2'd2: d = 16'd13107;
			default: d = 16'd22938;
		endcase
		return d;
	endfunction

	// round half up, then floor shift by 15
	function automatic wide_t rnd15(input wide_t v);
		wide_t t;
		t = v + 48'sd16384;
		return t >>> 15;
	endfunction

	function automatic sample_t sat24(input wide_t v);
		sample_t r;
		if (v > 48'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -48'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/multitap_allpass_reverb_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitap_allpass_reverb_unit
// Eight-tap feedback delay reverb with damping low-pass and allpass diffusers.
// ----------------------------------------------------------------------------
// channel  | signals                          | direction
// input    | in_valid, in_stall, in_sample    | request in, stall out
// output   | out_valid, out_stall, out_sample | request out, stall in
// config   | cfg_we, cfg_index, cfg_data      | write only, no wait
//
// A request runs from acceptance through the steps of the run state to the
// result register, and the next request is taken only after that: one step
// of a shared 24x17 multiplier per product, eight delay memory reads.
// After reset and after every register write the tap delays are rebuilt by a
// reciprocal multiply: a setup state, then load, divide and store per tap,
// in_stall high meanwhile and in the cycle of the write itself.
// The delay memory needs no clearing pass: unwritten entries are masked to zero.
// A stalled result holds in the output register while the next request runs.
// ----------------------------------------------------------------------------
module multitap_allpass_reverb_unit #(
	parameter int DELAY_DEPTH = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mtapverb_pkg::sample_t               in_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mtapverb_pkg::sample_t               out_sample,
	input  logic                                cfg_we,
	input  logic [mtapverb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtapverb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mtapverb_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DELAY_DEPTH);
	localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);
	localparam logic [31:0]   DMAX    = 32'(DELAY_DEPTH - 1);

	localparam logic [2:0] ST_BASE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_STORE = 3'd3;
	localparam logic [2:0] ST_IDLE  = 3'd4;
	localparam logic [2:0] ST_RUN   = 3'd5;

	localparam logic [4:0] S_TAP_END = 5'd7;
	localparam logic [4:0] S_ACC_END = 5'd9;
	localparam logic [4:0] S_TAPSUM  = 5'd10;
	localparam logic [4:0] S_LP0     = 5'd11;
	localparam logic [4:0] S_LP1     = 5'd12;
	localparam logic [4:0] S_LP2     = 5'd13;
	localparam logic [4:0] S_AP0     = 5'd14;
	localparam logic [4:0] S_AP_END  = 5'd25;
	localparam logic [4:0] S_FBK     = 5'd26;
	localparam logic [4:0] S_WRITE   = 5'd27;
	localparam logic [4:0] S_MIX1    = 5'd28;
	localparam logic [4:0] S_MIX2    = 5'd29;
	localparam logic [4:0] S_OUT     = 5'd30;

	// configuration registers
	logic [15:0] send_q;
	logic [14:0] fb_q;
	logic [6:0]  room_q;
	logic [15:0] damp_q;
	logic [1:0]  mode_q;
	logic [15:0] mix_q;
	logic [17:0] rate_q;

	// derived coefficients and tap delays
	logic signed [17:0] eff_q;
	logic [16:0]        c_q;
	logic [15:0]        fbk_q;
	logic [24:0]        base_q;
	logic [31:0]        num_q;
	logic [2:0]         tap_ix_q;
	logic [AW-1:0]      tap_delay_q [TAP_COUNT];

	// datapath state
	logic [2:0]         state_q;
	logic [4:0]         step_q;
	logic [AW-1:0]      wp_q;
	logic               wrapped_q;
	sample_t            x_q;
	logic signed [43:0] acc_q;
	logic signed [40:0] prod_q;
	logic signed [41:0] t_q;
	sample_t            tapsum_q;
	sample_t            lp_q;
	sample_t            wet_q;
	sample_t            o_q;
	sample_t            v_q;
	sample_t            ap_q [4];
	logic [1:0]         apk_q;
	logic [1:0]         ph_q;
	sample_t            y_q;
	sample_t            out_q;
	logic               out_valid_q;
	logic               rdv_s1;

	// memory port signals
	logic [AW-1:0] raddr;
	logic [23:0]   rdata;
	logic          mem_we;
	sample_t       wdata;

	logic signed [23:0] mul_a;
	logic signed [16:0] mul_b;
	logic [AW-1:0]      cur_d;
	logic [63:0]        quot;
	logic signed [47:0] cval;
	logic [2:0]         gix;
	logic               in_ap;
	logic               rebuild;
	logic               out_load;

	mtapverb_ram #(
		.WIDTH(24),
		.DEPTH(DELAY_DEPTH),
		.AW   (AW)
	) u_delay_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wp_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rebuild    = cfg_we && (cfg_index <= REG_RATE);
	assign in_stall   = (state_q != ST_IDLE) || rebuild;
	assign out_valid  = out_valid_q;
	assign out_sample = out_q;
	assign out_load   = (state_q == ST_RUN) && (step_q == S_OUT)
		&& (!out_valid_q || !out_stall);

	always_comb begin
		cur_d = tap_delay_q[step_q[2:0]];
		if (wp_q >= cur_d) begin
			raddr = wp_q - cur_d;
		end else begin
			raddr = AW'({1'b0, wp_q} + DEPTH_W - {1'b0, cur_d});
		end
	end

	assign quot   = num_q * TAP_RECIP;
	assign cval   = DAMP_OFS + rnd15(48'(eff_q) * DAMP_GAIN);
	assign gix    = 3'(step_q - 5'd1);
	assign in_ap  = (step_q >= S_AP0) && (step_q <= S_AP_END);
	assign mem_we = (state_q == ST_RUN) && (step_q == S_WRITE);
	assign wdata  = sat24(48'(x_q) + rnd15(48'(prod_q)));

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (step_q >= 5'd1 && step_q <= 5'd8) begin
			mul_a = rdv_s1 ? $signed(rdata) : 24'sd0;
			mul_b = $signed({1'b0, tap_gain(gix)});
		end else if (step_q == S_LP0) begin
			mul_a = tapsum_q;
			mul_b = 17'(18'sd32768 - $signed({1'b0, c_q}));
		end else if (step_q == S_LP1) begin
			mul_a = lp_q;
			mul_b = $signed(c_q);
		end else if (step_q == S_LP2) begin
			mul_a = tapsum_q;
			mul_b = $signed({1'b0, send_q});
		end else if (in_ap && ph_q != 2'd1) begin
			mul_a = o_q;
			mul_b = AP_COEF;
		end else if (step_q == S_FBK) begin
			mul_a = o_q;
			mul_b = $signed({1'b0, fbk_q});
		end else if (step_q == S_WRITE) begin
			mul_a = x_q;
			mul_b = 17'(18'sd32768 - $signed({2'b0, mix_q}));
		end else if (step_q == S_MIX1) begin
			mul_a = wet_q;
			mul_b = $signed({1'b0, mix_q});
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 41'(mul_a) * 41'(mul_b);
		rdv_s1 <= wrapped_q || (wp_q >= cur_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_q      <= 16'd9830;
			fb_q        <= 15'd19661;
			room_q      <= 7'd50;
			damp_q      <= 16'd16384;
			mode_q      <= 2'd0;
			mix_q       <= 16'd9830;
			rate_q      <= 18'd44100;
			state_q     <= ST_BASE;
			step_q      <= '0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			lp_q        <= '0;
			for (int i = 0; i < 4; i++) begin
				ap_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			tap_ix_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (rebuild) begin
				// rebuild tap delays and coefficients
				state_q <= ST_BASE;
			end else begin
				unique case (state_q)
					ST_BASE: begin
						base_q   <= 25'(room_q * rate_q);
						eff_q    <= 18'($signed({32'b0, preset_damp(mode_q)})
							+ rnd15(($signed({32'b0, damp_q}) - DAMP_MID) * DAMP_SCL));
						fbk_q    <= 16'(rnd15($signed({32'b0, preset_fb(mode_q)})
							* $signed({33'b0, fb_q})));
						tap_ix_q <= '0;
						state_q  <= ST_LOAD;
					end
					ST_LOAD: begin
						num_q <= 32'(base_q * tap_ratio(tap_ix_q));
						if (cval < 0) begin
							c_q <= '0;
						end else if (cval > UNITY) begin
							c_q <= 17'd32768;
						end else begin
							c_q <= cval[16:0];
						end
						state_q <= ST_DIV;
					end
					ST_DIV: begin
						// divide by 7300 through the scaled reciprocal
						num_q   <= 32'(quot >> TAP_SHIFT);
						state_q <= ST_STORE;
					end
					ST_STORE: begin
						if (num_q > DMAX) begin
							tap_delay_q[tap_ix_q] <= AW'(DMAX);
						end else if (num_q == 32'd0) begin
							tap_delay_q[tap_ix_q] <= AW'(1);
						end else begin
							tap_delay_q[tap_ix_q] <= AW'(num_q);
						end
						tap_ix_q <= tap_ix_q + 3'd1;
						state_q  <= (tap_ix_q == 3'(TAP_COUNT - 1)) ? ST_IDLE : ST_LOAD;
					end
					ST_IDLE: begin
						if (in_valid) begin
							x_q     <= in_sample;
							acc_q   <= '0;
							step_q  <= '0;
							state_q <= ST_RUN;
						end
					end
					ST_RUN: begin
						if (step_q != S_OUT) begin
							step_q <= step_q + 5'd1;
						end
						if (step_q >= 5'd2 && step_q <= S_ACC_END) begin
							acc_q <= acc_q + 44'(prod_q);
						end
						if (in_ap || step_q == S_FBK) begin
							ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
							if (ph_q == 2'd0) begin
								v_q <= o_q;
								if (step_q == S_AP0) begin
									wet_q <= sat24(rnd15(48'(prod_q)));
								end else begin
									ap_q[apk_q] <= sat24(48'(v_q) + rnd15(48'(prod_q)));
									apk_q       <= apk_q + 2'd1;
								end
							end else if (ph_q == 2'd1) begin
								o_q <= sat24(48'(ap_q[apk_q]) - rnd15(48'(prod_q)));
							end
						end
						unique case (step_q)
							S_TAPSUM: tapsum_q <= sat24(rnd15(48'(acc_q)));
							S_LP1:    t_q      <= 42'(prod_q);
							S_LP2: begin
								lp_q  <= sat24(rnd15(48'(t_q) + 48'(prod_q)));
								o_q   <= sat24(rnd15(48'(t_q) + 48'(prod_q)));
								ph_q  <= 2'd0;
								apk_q <= 2'd0;
							end
							S_WRITE: begin
								wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
								if (wp_q == WP_LAST) begin
									wrapped_q <= 1'b1;
								end
							end
							S_MIX1: t_q <= 42'(prod_q);
							S_MIX2: y_q <= sat24(rnd15(48'(t_q) + 48'(prod_q)));
							S_OUT: begin
								// hold until the output register is free
								if (out_load) begin
									out_q   <= y_q;
									state_q <= ST_IDLE;
								end
							end
							default: begin
							end
						endcase
					end
					default: state_q <= ST_BASE;
				endcase
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SEND:     send_q <= cfg_data[15:0];
					REG_FEEDBACK: fb_q   <= cfg_data[14:0];
					REG_ROOM:     room_q <= cfg_data[6:0];
					REG_DAMPING:  damp_q <= cfg_data[15:0];
					REG_MODE:     mode_q <= cfg_data[1:0];
					REG_MIX:      mix_q  <= cfg_data[15:0];
					REG_RATE:     rate_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/mtapverb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtapverb_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtapverb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
